### rtl/md5_custom_base64_digest_unit_assert.svh
// Assertion macros shared by the digest unit RTL.
`ifndef MD5_CUSTOM_BASE64_DIGEST_UNIT_ASSERT_SVH
`define MD5_CUSTOM_BASE64_DIGEST_UNIT_ASSERT_SVH

// Same-cycle implication, checked on clk_i outside reset.
`define MD5B64_ASSERT_NOW(lbl, pre, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (con)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i outside reset.
`define MD5B64_ASSERT_NXT(lbl, pre, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (con)) \
    else $error(msg);

`endif

### rtl/md5b64_pkg.sv
// ----------------------------------------------------------------------------
// md5b64_pkg
// Shared types and constants: MD5 round tables, output alphabet, control bus.
// ----------------------------------------------------------------------------
`default_nettype none

package md5b64_pkg;

  localparam int unsigned NumChars = 22;
  localparam logic [4:0]  LastChar = 5'd21;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] RoundK [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] RoundS [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // First symbol sits in the top byte.
  localparam logic [8*64-1:0] Alphabet = {
    "TSG8IncW3HFKokOg79qzeCmZs2yBYEQVAUxR5rbwi4P@jMDLtpva",
    "d0f_J1hlN6uX"
  };

  typedef struct packed {
    logic       wr_byte;  // store input byte, bump count
    logic       pad;      // 0x80 marker, zero tail, length if it fits
    logic       pad2;     // extra padding block: zeros plus length
    logic       load;     // working regs <= chain
    logic       round;    // one MD5 round
    logic       fin;      // chain += working regs
    logic       restart;  // chain and count back to init
    logic [5:0] rnd;
    logic [4:0] chr;
  } cmd_t;

  typedef struct packed {
    logic [5:0] pos;      // byte position in current block
  } st_t;

endpackage

`default_nettype wire

### rtl/md5_custom_base64_digest_unit.sv
// ----------------------------------------------------------------------------
// md5_custom_base64_digest_unit
// MD5 over a byte stream, digest emitted as 22 chars of a custom alphabet.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  in      | in  | in_valid_i/in_ready_o  | data_byte_i, has_byte_i, last_i
//  out     | out | out_valid_o/out_ready_i| digest_char_o, last_char_o
//
// A byte is taken whenever the unit is idle; the 64th byte of a block starts
// the compression (load, 64 rounds of the single round unit, chain update).
// A last item adds a padding step per padded block and one or two
// compressions, then 22 chars at one per cycle when not stalled.
// Reset loads the MD5 init vector and clears the count; the block buffer is
// not reset. Input is held off while compressing or emitting; an output
// stall simply holds the current char.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_custom_base64_digest_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       has_byte_i,
  input  wire logic       last_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      digest_char_o,
  output logic            last_char_o
);
  import md5b64_pkg::*;

  cmd_t cmd;
  st_t  st;

  // Sequencer: decides when bytes land, when blocks compress, char index.
  md5b64_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .has_byte_i  (has_byte_i),
    .last_i      (last_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .last_char_o (last_char_o),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  // Storage, round unit and char mapping.
  md5b64_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_byte_i   (data_byte_i),
    .cmd_i         (cmd),
    .st_o          (st),
    .digest_char_o (digest_char_o)
  );

endmodule

`default_nettype wire

### rtl/md5b64_dp.sv
// ----------------------------------------------------------------------------
// md5b64_dp
// Datapath: block buffer, chaining words, byte count, round unit, char mux.
// ----------------------------------------------------------------------------
`default_nettype none

module md5b64_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [7:0]        data_byte_i,
  input  wire md5b64_pkg::cmd_t  cmd_i,
  output md5b64_pkg::st_t        st_o,
  output logic [7:0]             digest_char_o
);
  import md5b64_pkg::*;

  logic [31:0] buf_q [16];
  logic [31:0] chain_q [4];
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [60:0] cnt_q;

  logic [5:0]  pos;
  logic [3:0]  wsel;
  logic [1:0]  lane;
  logic [7:0]  wbyte;
  logic [63:0] bits;
  logic [5:0]  ri;
  logic [31:0] f, g_word, sum, rot;
  logic [3:0]  g;
  logic [4:0]  s;
  logic [63:0] rot2;

  assign pos   = cnt_q[5:0];
  assign wsel  = pos[5:2];
  assign lane  = pos[1:0];
  assign wbyte = cmd_i.pad ? PadByte : data_byte_i;
  assign bits  = {cnt_q, 3'b000};
  assign st_o.pos = pos;

  // Round function
  assign ri = cmd_i.rnd;
  always_comb begin
    case (ri[5:4])
      2'd0: begin
        f = (b_q & c_q) | (~b_q & d_q);
        g = ri[3:0];
      end
      2'd1: begin
        f = (d_q & b_q) | (~d_q & c_q);
        g = 4'(ri[3:0] * 4'd5 + 4'd1);
      end
      2'd2: begin
        f = b_q ^ c_q ^ d_q;
        g = 4'(ri[3:0] * 4'd3 + 4'd5);
      end
      default: begin
        f = c_q ^ (b_q | ~d_q);
        g = 4'(ri[3:0] * 4'd7);
      end
    endcase
  end

  assign g_word = buf_q[g];
  assign s      = RoundS[{ri[5:4], ri[1:0]}];
  assign sum    = a_q + f + RoundK[ri] + g_word;
  assign rot2   = {sum, sum} << s;
  assign rot    = rot2[63:32];

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 16; j++) begin
      if ((cmd_i.wr_byte || cmd_i.pad) && wsel == 4'(j)) begin
        if (lane == 2'd0) buf_q[j] <= {24'd0, wbyte};
        else              buf_q[j][8*lane +: 8] <= wbyte;
      end else if (cmd_i.pad && 4'(j) > wsel) begin
        if (j == 14 && wsel < 4'd14)      buf_q[j] <= bits[31:0];
        else if (j == 15 && wsel < 4'd14) buf_q[j] <= bits[63:32];
        else                              buf_q[j] <= '0;
      end else if (cmd_i.pad2) begin
        if (j == 14)      buf_q[j] <= bits[31:0];
        else if (j == 15) buf_q[j] <= bits[63:32];
        else              buf_q[j] <= '0;
      end
    end
    if (cmd_i.load) begin
      a_q <= chain_q[0];
      b_q <= chain_q[1];
      c_q <= chain_q[2];
      d_q <= chain_q[3];
    end else if (cmd_i.round) begin
      a_q <= d_q;
      d_q <= c_q;
      c_q <= b_q;
      b_q <= b_q + rot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q[0] <= InitA;
      chain_q[1] <= InitB;
      chain_q[2] <= InitC;
      chain_q[3] <= InitD;
      cnt_q      <= '0;
    end else if (cmd_i.restart) begin
      chain_q[0] <= InitA;
      chain_q[1] <= InitB;
      chain_q[2] <= InitC;
      chain_q[3] <= InitD;
      cnt_q      <= '0;
    end else begin
      if (cmd_i.wr_byte) cnt_q <= cnt_q + 61'd1;
      if (cmd_i.fin) begin
        chain_q[0] <= chain_q[0] + a_q;
        chain_q[1] <= chain_q[1] + b_q;
        chain_q[2] <= chain_q[2] + c_q;
        chain_q[3] <= chain_q[3] + d_q;
      end
    end
  end

  // Digest bit stream, byte 0 first, with four zero bits for the tail char.
  logic [131:0] dgx;
  logic [131:0] dsh;
  logic [7:0]   shamt;
  logic [5:0]   grp;

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      dgx[131 - 8*k -: 8] = chain_q[k/4][8*(k%4) +: 8];
    end
    dgx[3:0] = 4'b0000;
  end

  assign shamt = 8'd126 - 8'(cmd_i.chr) * 8'd6;
  assign dsh   = dgx >> shamt;
  assign grp   = dsh[5:0];
  assign digest_char_o = Alphabet[8*(7'd63 - 7'(grp)) +: 8];

endmodule

`default_nettype wire

### rtl/md5b64_ctrl.sv
// ----------------------------------------------------------------------------
// md5b64_ctrl
// Sequencer: accepts bytes, runs compressions, padding and char output.
// ----------------------------------------------------------------------------
`default_nettype none

module md5b64_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             has_byte_i,
  input  wire logic             last_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic                  last_char_o,
  input  wire md5b64_pkg::st_t  st_i,
  output md5b64_pkg::cmd_t      cmd_o
);
  import md5b64_pkg::*;
  `include "md5_custom_base64_digest_unit_assert.svh"

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_PAD2, S_LOAD, S_RND, S_FIN, S_OUT
  } state_e;

  typedef enum logic [1:0] {
    R_IDLE, R_PAD, R_PAD2, R_OUT
  } ret_e;

  state_e     state_q;
  ret_e       ret_q;
  logic [5:0] rnd_q;
  logic [4:0] chr_q;
  logic       in_xfer, out_xfer;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign last_char_o = (chr_q == LastChar);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_xfer    = out_valid_o && out_ready_i;

  always_comb begin
    cmd_o         = '0;
    cmd_o.wr_byte = in_xfer && has_byte_i;
    cmd_o.pad     = (state_q == S_PAD);
    cmd_o.pad2    = (state_q == S_PAD2);
    cmd_o.load    = (state_q == S_LOAD);
    cmd_o.round   = (state_q == S_RND);
    cmd_o.fin     = (state_q == S_FIN);
    cmd_o.restart = out_xfer && last_char_o;
    cmd_o.rnd     = rnd_q;
    cmd_o.chr     = chr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= R_IDLE;
      rnd_q   <= '0;
      chr_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            if (has_byte_i && st_i.pos == 6'd63) begin
              state_q <= S_LOAD;
              ret_q   <= last_i ? R_PAD : R_IDLE;
            end else if (last_i) begin
              state_q <= S_PAD;
            end
          end
        end
        S_PAD: begin
          state_q <= S_LOAD;
          ret_q   <= (st_i.pos[5:3] == 3'b111) ? R_PAD2 : R_OUT;
        end
        S_PAD2: begin
          state_q <= S_LOAD;
          ret_q   <= R_OUT;
        end
        S_LOAD: begin
          rnd_q   <= '0;
          state_q <= S_RND;
        end
        S_RND: begin
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) state_q <= S_FIN;
        end
        S_FIN: begin
          chr_q <= '0;
          unique case (ret_q)
            R_IDLE: state_q <= S_IDLE;
            R_PAD:  state_q <= S_PAD;
            R_PAD2: state_q <= S_PAD2;
            R_OUT:  state_q <= S_OUT;
          endcase
        end
        S_OUT: begin
          if (out_xfer) begin
            if (last_char_o) state_q <= S_IDLE;
            else             chr_q   <= chr_q + 5'd1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `MD5B64_ASSERT_NOW(a_no_overlap, out_valid_o, !in_ready_o, "output while taking input")
  `MD5B64_ASSERT_NXT(a_fin_after_rnd, (state_q == S_RND) && (rnd_q == 6'd63),
                     state_q == S_FIN, "round 63 not followed by finalize")
  `MD5B64_ASSERT_NXT(a_idle_after_last, out_xfer && last_char_o, in_ready_o,
                     "not idle after final char")
  `MD5B64_ASSERT_NOW(a_chr_range, out_valid_o, chr_q <= LastChar, "char index out of range")

endmodule

`default_nettype wire
